// File: src/clb_pkg.sv
// ----------------------------------------------------------------------------
// clb_pkg
// Shared types, sizes and codes for the linked cell list binning block.
// ----------------------------------------------------------------------------
package clb_pkg;

	localparam int MAX_ATOMS          = 1024;
	localparam int MAX_CELLS_PER_SIDE = 16;
	localparam int CELL_DEPTH         = MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE
	                                    * MAX_CELLS_PER_SIDE;
	localparam int CELL_AW            = $clog2(CELL_DEPTH);
	localparam int ATOM_AW            = $clog2(MAX_ATOMS);
	localparam int CNT_W              = ATOM_AW + 1;
	localparam int LINK_W             = ATOM_AW + 1;
	localparam int SIDE_W             = 5;
	localparam int POS_W              = 32;
	localparam int HALF_W             = 31;
	localparam int INV_W              = 32;
	localparam int FRAC_SHIFT         = 40;
	localparam int QUOT_W             = POS_W + INV_W - FRAC_SHIFT;
	localparam int IDX_W              = $clog2(MAX_CELLS_PER_SIDE);
	localparam int CUBE_W             = 3 * SIDE_W;

	localparam logic [LINK_W-1:0] EMPTY_LINK = '1;

	localparam logic [1:0] CFG_CELLS_PER_SIDE  = 2'd0;
	localparam logic [1:0] CFG_HALF_BOX        = 2'd1;
	localparam logic [1:0] CFG_INV_CELL_LENGTH = 2'd2;

	localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd1;
	localparam logic [HALF_W-1:0] HALF_RESET = '0;
	localparam logic [INV_W-1:0]  INV_RESET  = 32'd16777216;

	typedef enum logic [1:0] {
		CMD_CLEAR     = 2'd0,
		CMD_INSERT    = 2'd1,
		CMD_READ_HEAD = 2'd2,
		CMD_READ_LINK = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} st_code_t;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_AX_ADD,
		S_AX_MUL,
		S_AX_CHK,
		S_MEM_RD,
		S_MEM_WAIT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic accept;
		logic sweep;
		logic ax_add;
		logic ax_mul;
		logic ax_chk;
		logic mem_rd;
		logic mem_done;
		logic load_out;
	} clb_ctl_t;

	typedef struct packed {
		cmd_code_t cmd;
		logic      side_ok;
		logic      head_query_ok;
		logic      link_query_ok;
		logic      sweep_last;
		logic      ax_ok;
		logic      ax_last;
		logic      store_full;
	} clb_sts_t;

endpackage

// File: src/clb_ram.sv
// ----------------------------------------------------------------------------
// clb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module clb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/clb_ctrl.sv
// ----------------------------------------------------------------------------
// clb_ctrl
// Sequencer for the cell list block: handshakes, axis loop, memory access
// and the clearing sweep of the head table.
// ----------------------------------------------------------------------------
module clb_ctrl
	import clb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  clb_sts_t sts,
	output clb_ctl_t ctl
);

	state_t state_q, state_d;
	logic   emit_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SWEEP: begin
				if (sts.sweep_last) begin
					state_d = emit_q ? S_RESP : S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					unique case (sts.cmd)
						CMD_CLEAR:     state_d = S_SWEEP;
						CMD_INSERT:    state_d = sts.side_ok ? S_AX_ADD : S_RESP;
						CMD_READ_HEAD: state_d = sts.head_query_ok ? S_MEM_RD : S_RESP;
						CMD_READ_LINK: state_d = sts.link_query_ok ? S_MEM_RD : S_RESP;
						default:       state_d = S_IDLE;
					endcase
				end
			end
			S_AX_ADD: state_d = S_AX_MUL;
			S_AX_MUL: state_d = S_AX_CHK;
			S_AX_CHK: begin
				if (!sts.ax_ok) begin
					state_d = S_RESP;
				end else if (sts.ax_last) begin
					state_d = sts.store_full ? S_RESP : S_MEM_RD;
				end else begin
					state_d = S_AX_ADD;
				end
			end
			S_MEM_RD:   state_d = S_MEM_WAIT;
			S_MEM_WAIT: state_d = S_RESP;
			S_RESP: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl          = '0;
		ctl.accept   = (state_q == S_IDLE) && in_valid;
		ctl.sweep    = (state_q == S_SWEEP);
		ctl.ax_add   = (state_q == S_AX_ADD);
		ctl.ax_mul   = (state_q == S_AX_MUL);
		ctl.ax_chk   = (state_q == S_AX_CHK);
		ctl.mem_rd   = (state_q == S_MEM_RD);
		ctl.mem_done = (state_q == S_MEM_WAIT);
		ctl.load_out = (state_q == S_RESP) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.accept) begin
				emit_q <= 1'b1;
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: src/clb_datapath.sv
// ----------------------------------------------------------------------------
// clb_datapath
// Configuration registers, axis index arithmetic, head and link tables,
// atom counter and result registers.
// ----------------------------------------------------------------------------
module clb_datapath
	import clb_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [31:0]              cfg_data,
	input  logic [1:0]               cmd,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic [CELL_AW-1:0]       query_cell,
	input  logic [ATOM_AW-1:0]       query_atom,
	input  clb_ctl_t                 ctl,
	output clb_sts_t                 sts,
	output logic [CELL_AW-1:0]       cell_number,
	output logic signed [LINK_W-1:0] link_value,
	output logic [ATOM_AW-1:0]       atom_number,
	output logic [1:0]               status
);

	logic [SIDE_W-1:0]  side_q;
	logic [HALF_W-1:0]  half_q;
	logic [INV_W-1:0]   inv_q;

	cmd_code_t          cmd_q;
	logic [POS_W-1:0]   pos_x_q, pos_y_q, pos_z_q;
	logic [1:0]         ax_q;
	logic [CELL_AW-1:0] acc_q;
	logic [POS_W-1:0]   mag_q;
	logic               neg_q;
	logic [63:0]        prod_q;
	logic [CNT_W-1:0]   atom_count_q;
	logic [CELL_AW-1:0] sweep_q;

	logic [CELL_AW-1:0] res_cell_q;
	logic [LINK_W-1:0]  res_link_q;
	logic [ATOM_AW-1:0] res_atom_q;
	st_code_t           res_status_q;

	logic [CELL_AW-1:0] out_cell_q;
	logic [LINK_W-1:0]  out_link_q;
	logic [ATOM_AW-1:0] out_atom_q;
	st_code_t           out_status_q;

	logic               side_ok;
	logic [2*SIDE_W-1:0] side_sq;
	logic [CUBE_W-1:0]  cube;
	logic [POS_W-1:0]   pos_sel;
	logic [POS_W:0]     sum;
	logic [POS_W:0]     sum_neg;
	logic [QUOT_W-1:0]  quot;
	logic               ax_ok;
	logic [IDX_W-1:0]   idx;
	logic [CELL_AW+SIDE_W-1:0] acc_wide;
	logic [CELL_AW-1:0] acc_next;
	logic               store_full;

	logic               head_we;
	logic [CELL_AW-1:0] head_waddr;
	logic [LINK_W-1:0]  head_wdata;
	logic [LINK_W-1:0]  head_rdata;
	logic               link_we;
	logic [LINK_W-1:0]  link_rdata;

	assign side_ok = (side_q != '0) && (side_q <= SIDE_W'(MAX_CELLS_PER_SIDE));
	assign side_sq = side_q * side_q;
	assign cube    = side_sq * side_q;

	always_comb begin
		case (ax_q)
			2'd0:    pos_sel = pos_z_q;
			2'd1:    pos_sel = pos_y_q;
			default: pos_sel = pos_x_q;
		endcase
	end

	assign sum     = {pos_sel[POS_W-1], pos_sel} + {2'b00, half_q};
	assign sum_neg = -sum;

	assign quot     = prod_q[63:FRAC_SHIFT];
	assign ax_ok    = neg_q ? (quot == '0)
	                        : (quot < {{(QUOT_W-SIDE_W){1'b0}}, side_q});
	assign idx      = neg_q ? '0 : quot[IDX_W-1:0];
	assign acc_wide = acc_q * side_q;
	assign acc_next = acc_wide[CELL_AW-1:0] + {{(CELL_AW-IDX_W){1'b0}}, idx};

	assign store_full = (atom_count_q == CNT_W'(MAX_ATOMS));

	always_comb begin
		sts               = '0;
		sts.cmd           = cmd_code_t'(cmd);
		sts.side_ok       = side_ok;
		sts.head_query_ok = side_ok && ({3'b000, query_cell} < cube);
		sts.link_query_ok = ({1'b0, query_atom} < atom_count_q);
		sts.sweep_last    = (sweep_q == '1);
		sts.ax_ok         = ax_ok;
		sts.ax_last       = (ax_q == 2'd2);
		sts.store_full    = store_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
			half_q <= HALF_RESET;
			inv_q  <= INV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CELLS_PER_SIDE:  side_q <= cfg_data[SIDE_W-1:0];
				CFG_HALF_BOX:        half_q <= cfg_data[HALF_W-1:0];
				CFG_INV_CELL_LENGTH: inv_q  <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_count_q <= '0;
			sweep_q      <= '0;
		end else begin
			if (ctl.accept && (cmd_code_t'(cmd) == CMD_CLEAR)) begin
				atom_count_q <= '0;
				sweep_q      <= '0;
			end
			if (ctl.sweep) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (ctl.mem_done && (cmd_q == CMD_INSERT)) begin
				atom_count_q <= atom_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q      <= cmd_code_t'(cmd);
			pos_x_q    <= pos_x;
			pos_y_q    <= pos_y;
			pos_z_q    <= pos_z;
			ax_q       <= '0;
			acc_q      <= '0;
			res_cell_q <= (cmd_code_t'(cmd) == CMD_READ_HEAD) ? query_cell : '0;
			res_link_q <= EMPTY_LINK;
			res_atom_q <= (cmd_code_t'(cmd) == CMD_READ_LINK) ? query_atom : '0;
			res_status_q <= (((cmd_code_t'(cmd) == CMD_INSERT) && !side_ok)
				|| ((cmd_code_t'(cmd) == CMD_READ_HEAD) && !sts.head_query_ok))
				? ST_RANGE : ST_OK;
		end
		if (ctl.ax_add) begin
			neg_q <= sum[POS_W];
			mag_q <= sum[POS_W] ? sum_neg[POS_W-1:0] : sum[POS_W-1:0];
		end
		if (ctl.ax_mul) begin
			prod_q <= mag_q * inv_q;
		end
		if (ctl.ax_chk) begin
			acc_q <= acc_next;
			ax_q  <= ax_q + 1'b1;
			if (!ax_ok) begin
				res_status_q <= ST_RANGE;
			end else if (ax_q == 2'd2) begin
				res_cell_q <= acc_next;
				if (store_full) begin
					res_status_q <= ST_FULL;
				end
			end
		end
		if (ctl.mem_done) begin
			case (cmd_q)
				CMD_INSERT: begin
					res_link_q <= head_rdata;
					res_atom_q <= atom_count_q[ATOM_AW-1:0];
				end
				CMD_READ_HEAD: res_link_q <= head_rdata;
				CMD_READ_LINK: res_link_q <= link_rdata;
				default: ;
			endcase
		end
		if (ctl.load_out) begin
			out_cell_q   <= res_cell_q;
			out_link_q   <= res_link_q;
			out_atom_q   <= res_atom_q;
			out_status_q <= res_status_q;
		end
	end

	assign head_we    = ctl.sweep || (ctl.mem_done && (cmd_q == CMD_INSERT));
	assign head_waddr = ctl.sweep ? sweep_q : res_cell_q;
	assign head_wdata = ctl.sweep ? EMPTY_LINK : atom_count_q;
	assign link_we    = ctl.mem_done && (cmd_q == CMD_INSERT);

	clb_ram #(
		.WIDTH (LINK_W),
		.DEPTH (CELL_DEPTH)
	) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (res_cell_q),
		.rdata (head_rdata)
	);

	clb_ram #(
		.WIDTH (LINK_W),
		.DEPTH (MAX_ATOMS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (atom_count_q[ATOM_AW-1:0]),
		.wdata (head_rdata),
		.raddr (res_atom_q),
		.rdata (link_rdata)
	);

	assign cell_number = out_cell_q;
	assign link_value  = out_link_q;
	assign atom_number = out_atom_q;
	assign status      = out_status_q;

endmodule

// File: src/cell_list_binning.sv
// ----------------------------------------------------------------------------
// cell_list_binning
// Linked cell list builder: bins Q16.16 positions into cubic cells and keeps
// a head per cell and a next link per atom.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) takes one command item: clear,
// insert, read a cell head or read an atom's next link. The output channel
// (out_valid/out_ready) returns exactly one result item per command.
// The block works on one item at a time; in_ready is high only when idle.
// An insert makes three passes of add, multiply and range check through one
// shared 32 by 32 multiplier, then reads the head table and writes the head
// and link tables. A cell head read and a next link read each pass through
// a memory read state and a wait state before the result state. A command
// rejected on acceptance goes straight to the result state.
// A clear sweeps the 4096-entry head table one entry per cycle and then
// returns its result.
// After reset the same full sweep runs with in_ready low and no item
// is produced; configuration writes are taken at any time.
// The result sits in an output register; while the receiver stalls, the
// block may still accept and work on the next item, which then waits until
// the output register is free.
// ----------------------------------------------------------------------------
module cell_list_binning
	import clb_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [31:0]              cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               cmd,
	input  logic signed [31:0]       pos_x,
	input  logic signed [31:0]       pos_y,
	input  logic signed [31:0]       pos_z,
	input  logic [11:0]              query_cell,
	input  logic [9:0]               query_atom,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [11:0]              cell_number,
	output logic signed [10:0]       link_value,
	output logic [9:0]               atom_number,
	output logic [1:0]               status
);

	clb_ctl_t ctl;
	clb_sts_t sts;

	clb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	clb_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.query_cell  (query_cell),
		.query_atom  (query_atom),
		.ctl         (ctl),
		.sts         (sts),
		.cell_number (cell_number),
		.link_value  (link_value),
		.atom_number (atom_number),
		.status      (status)
	);

endmodule

// File: src/clb_checker.sv
// ----------------------------------------------------------------------------
// clb_checker
// Port-level checks of the cell list block, bound to the top level.
// ----------------------------------------------------------------------------
module clb_checker
	import clb_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [11:0]        cell_number,
	input logic signed [10:0] link_value,
	input logic [9:0]         atom_number,
	input logic [1:0]         status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cell_number)
			&& $stable(link_value) && $stable(atom_number) && $stable(status))
		else $error("Stalled result item changed.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK) || (status == ST_RANGE) || (status == ST_FULL))
		else $error("Result item carries an unknown status.");

	a_reject_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == ST_RANGE) || (status == ST_FULL))
			|-> (link_value == -11'sd1) && (atom_number == '0))
		else $error("Rejected item reports a link or an atom.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Item accepted while the previous one is in work.");

endmodule

bind cell_list_binning clb_checker u_clb_checker (.*);
